// ----- sv/mf3_pkg.sv -----
// Shared types, constants and helper functions of the 3x3 median filter.
package mf3_pkg;

  localparam int PIX_BITS        = 8;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int CFG_W_BITS      = 11;
  localparam int CFG_H_BITS      = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int RESULTS_MAX     = 4;
  localparam int KIND_BITS       = $clog2(RESULTS_MAX);

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd480;

  typedef logic [PIX_BITS-1:0] pix_t;
  // Nine window samples, index col * 3 + row.
  typedef pix_t [8:0] nine_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Which neighbourhood a result uses; also its position in the per-pixel order.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_INNER    = 2'd0, // row above, full window
    KIND_LAST_ROW = 2'd1, // bottom row replicated
    KIND_END_COL  = 2'd2, // right column replicated
    KIND_CORNER   = 2'd3  // both replicated, last pixel of the image
  } result_kind_e;

  typedef struct packed {
    logic run_last;
    logic frame_last;
  } res_flags_t;

  // Gather the nine samples of one neighbourhood, grouped by column.
  function automatic nine_t select_window(nine_t win, result_kind_e kind);
    nine_t res;
    int    ci;
    int    rk;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ci = kind[1] ? ((i == 0) ? 1 : 2) : i;
        rk = kind[0] ? ((k == 0) ? 1 : 2) : k;
        res[i*3+k] = win[ci*3+rk];
      end
    end
    return res;
  endfunction

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Ascending sort of three samples: [0] low, [1] middle, [2] high.
  function automatic pix_t [2:0] sort3(pix_t a, pix_t b, pix_t c);
    pix_t [2:0] res;
    res[0] = min2(min2(a, b), c);
    res[2] = max2(max2(a, b), c);
    res[1] = med3(a, b, c);
    return res;
  endfunction

endpackage

// ----- sv/median_filter_3x3_edge_replicate.sv -----
// Top level of the 3x3 edge-replicating median filter over an 8-bit raster stream.
//
// Usage:
//   Pixels enter in raster order on the s_axis beat channel (tdata = pixel).
//   Results leave on m_axis: tdata = median, tlast = last result caused by
//   the input pixel, tuser = last pixel of the image. Output runs one row
//   behind the input; on the last input row the final row is flushed in
//   the same pass, so one pixel can cause up to four results.
//   The user writes width and height on the cfg channel (index 0 width,
//   index 1 height) while the block is idle (unchecked; cfg_ready_o is always high).
// Throughput: one pixel per clock while each pixel causes at most one result and
//   m_axis is not stalled; a pixel causing more holds the input until the single
//   median pipeline, which takes one neighbourhood per cycle, has taken them all.
//   Both line stores are read and written once per pixel, with forwarding between neighbors.
// Path: a result reaches m_axis through the line store read, the window update
//   and three median stages after the beat that caused it.
// Reset: counters, window and all valid flags clear; width 640, height 480.
//   Line store contents stay undefined and need no clearing pass.
// Stall: when m_axis_tready is low the median pipeline holds and fills, then
//   s_axis_tready drops; no beat is lost or repeated.
module median_filter_3x3_edge_replicate #(
  parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input beats: tdata[7:0] in_pixel
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  // Output beats: tdata[7:0] out_pixel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,
  output logic                              m_axis_tlast,
  // tuser[0] frame_last
  output logic [0:0]                        m_axis_tuser,
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [0:0]                        cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef struct packed {
    logic col_zero;
    logic col_ge1;
    logic row_ge1;
    logic row_ge2;
    logic last_row;
    logic end_row;
  } pos_t;

  // Configuration
  logic [mf3_pkg::CFG_W_BITS-1:0] width_q;
  logic [mf3_pkg::CFG_H_BITS-1:0] height_q;
  logic                           cfg_fire;

  // Position counters and derived limits
  logic [CW-1:0] col_q, col_d, last_col, idx_a;
  logic [RW-1:0] row_q, row_d, last_row_idx;
  logic          in_fire;
  pos_t          pos_a;

  // Line stores
  mf3_pkg::pix_t older_mem [MAX_WIDTH];
  mf3_pkg::pix_t newer_mem [MAX_WIDTH];
  mf3_pkg::pix_t older_rd_q, newer_rd_q;

  // Execute stage
  logic          sb_valid_q, sb_exec;
  logic [CW-1:0] sb_idx_q;
  mf3_pkg::pix_t sb_pix_q;
  pos_t          sb_pos_q;
  logic          fwd_q;
  mf3_pkg::pix_t fwd_newer_q, fwd_older_q;
  mf3_pkg::pix_t newer_eff, older_eff, mid_pix, top_pix;

  // Window and result sequencer
  mf3_pkg::nine_t                   win_q;
  logic [mf3_pkg::RESULTS_MAX-1:0]  job_q, job_d, job_clr, job_new;
  mf3_pkg::result_kind_e            kind;
  logic                             iss_valid, iss_fire, med_ready;
  mf3_pkg::res_flags_t              iss_flags, out_flags;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mf3_pkg::WIDTH_RESET;
      height_q <= mf3_pkg::HEIGHT_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        mf3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[mf3_pkg::CFG_W_BITS-1:0];
        mf3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[mf3_pkg::CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the programmed size into 1..MAX and turn it into a last index.
  always_comb begin
    if (width_q == '0) begin
      last_col = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(width_q - 1'b1);
    end
    if (height_q == '0) begin
      last_row_idx = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      last_row_idx = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row_idx = RW'(height_q - 1'b1);
    end
  end

  // ------------------------------------------------------------- accept
  assign s_axis_tready = !sb_valid_q || sb_exec;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pos_a.col_zero = (col_q == '0);
    pos_a.col_ge1  = (col_q != '0);
    pos_a.row_ge1  = (row_q != '0);
    pos_a.row_ge2  = (32'(row_q) >= 2);
    pos_a.last_row = (row_q >= last_row_idx);
    pos_a.end_row  = (col_q >= last_col);
    idx_a = (32'(col_q) < MAX_WIDTH) ? col_q : CW'(MAX_WIDTH - 1);
    if (pos_a.end_row) begin
      col_d = '0;
      row_d = pos_a.last_row ? '0 : RW'(row_q + 1'b1);
    end else begin
      col_d = CW'(col_q + 1'b1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------- line stores
  // Read at accept, write back at execute; the rows shift down one store.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      older_rd_q <= older_mem[idx_a];
      newer_rd_q <= newer_mem[idx_a];
    end
    if (sb_exec) begin
      older_mem[sb_idx_q] <= newer_eff;
      newer_mem[sb_idx_q] <= sb_pix_q;
    end
  end

  // -------------------------------------------------------- execute stage
  // Forward the predecessor's write when it hits the entry just read
  // (single-column images, or a width change mid-row).
  assign newer_eff = fwd_q ? fwd_newer_q : newer_rd_q;
  assign older_eff = fwd_q ? fwd_older_q : older_rd_q;
  assign mid_pix   = sb_pos_q.row_ge1 ? newer_eff : sb_pix_q;
  assign top_pix   = sb_pos_q.row_ge2 ? older_eff : mid_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        sb_valid_q <= 1'b1;
        fwd_q      <= sb_valid_q && sb_exec && (sb_idx_q == idx_a);
      end else if (sb_exec) begin
        sb_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sb_idx_q    <= idx_a;
      sb_pix_q    <= s_axis_tdata;
      sb_pos_q    <= pos_a;
      fwd_newer_q <= sb_pix_q;
      fwd_older_q <= newer_eff;
    end
  end

  // Pending results of the current window, in emission order.
  always_comb begin
    job_new = '0;
    job_new[mf3_pkg::KIND_INNER]    = sb_pos_q.col_ge1 && sb_pos_q.row_ge1;
    job_new[mf3_pkg::KIND_LAST_ROW] = sb_pos_q.col_ge1 && sb_pos_q.last_row;
    job_new[mf3_pkg::KIND_END_COL]  = sb_pos_q.end_row && sb_pos_q.row_ge1;
    job_new[mf3_pkg::KIND_CORNER]   = sb_pos_q.end_row && sb_pos_q.last_row;
  end

  always_comb begin
    if (job_q[mf3_pkg::KIND_INNER]) begin
      kind = mf3_pkg::KIND_INNER;
    end else if (job_q[mf3_pkg::KIND_LAST_ROW]) begin
      kind = mf3_pkg::KIND_LAST_ROW;
    end else if (job_q[mf3_pkg::KIND_END_COL]) begin
      kind = mf3_pkg::KIND_END_COL;
    end else begin
      kind = mf3_pkg::KIND_CORNER;
    end
    job_clr       = job_q;
    job_clr[kind] = 1'b0;
  end

  assign iss_valid = |job_q;
  assign iss_fire  = iss_valid && med_ready;
  // Replace the window only once its last result is on its way.
  assign sb_exec   = sb_valid_q && ((job_q == '0) || (iss_fire && (job_clr == '0)));

  assign iss_flags.run_last   = (job_clr == '0);
  assign iss_flags.frame_last = (kind == mf3_pkg::KIND_CORNER);

  always_comb begin
    if (sb_exec) begin
      job_d = job_new;
    end else if (iss_fire) begin
      job_d = job_clr;
    end else begin
      job_d = job_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= '0;
      win_q <= '0;
    end else begin
      job_q <= job_d;
      if (sb_exec) begin
        if (sb_pos_q.col_zero) begin
          // Start of row: replicate the first column to the left.
          for (int i = 0; i < 3; i++) begin
            win_q[i*3+0] <= top_pix;
            win_q[i*3+1] <= mid_pix;
            win_q[i*3+2] <= sb_pix_q;
          end
        end else begin
          for (int i = 0; i < 6; i++) begin
            win_q[i] <= win_q[i+3];
          end
          win_q[6] <= top_pix;
          win_q[7] <= mid_pix;
          win_q[8] <= sb_pix_q;
        end
      end
    end
  end

  // ------------------------------------------------------------- median
  mf3_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (iss_valid),
    .in_ready_o  (med_ready),
    .in_win_i    (mf3_pkg::select_window(win_q, kind)),
    .in_flags_i  (iss_flags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_flags_o (out_flags)
  );

  assign m_axis_tlast    = out_flags.run_last;
  assign m_axis_tuser[0] = out_flags.frame_last;

`ifndef SYNTH
  // The end-of-image beat is always the last one of its run.
  a_frame_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("frame_last without run_last");

  // Hold the window while any of its results has yet to be issued.
  a_window_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((job_q != '0) && !(iss_fire && (job_clr == '0))) |=> $stable(win_q))
    else $error("window changed with results pending");

  // Forwarding only ever covers a repeat of the previous entry.
  a_forward_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && sb_valid_q && sb_exec && (sb_idx_q == idx_a)) |=>
      (fwd_q && (sb_idx_q == $past(sb_idx_q))))
    else $error("forwarding from a different line store entry");
`endif

endmodule

// ----- sv/mf3_median.sv -----
// Three-stage median-of-nine pipeline with stall, output register last.
module mf3_median (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mf3_pkg::nine_t      in_win_i,
  input  mf3_pkg::res_flags_t in_flags_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mf3_pkg::pix_t       out_pixel_o,
  output mf3_pkg::res_flags_t out_flags_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  mf3_pkg::pix_t [2:0] lo_d, md_d, hi_d;
  mf3_pkg::nine_t      s1_q;
  mf3_pkg::pix_t [2:0] s2_q;
  mf3_pkg::pix_t       s3_q;
  mf3_pkg::res_flags_t f1_q, f2_q, f3_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // Stage 1 sorts each column; stage 2 takes max of lows, median of middles,
  // min of highs; stage 3 the median of those three.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_d[i] = s1_q[i*3+0];
      md_d[i] = s1_q[i*3+1];
      hi_d[i] = s1_q[i*3+2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        {s1_q[i*3+2], s1_q[i*3+1], s1_q[i*3+0]} <=
          mf3_pkg::sort3(in_win_i[i*3+0], in_win_i[i*3+1], in_win_i[i*3+2]);
      end
      f1_q <= in_flags_i;
    end
    if (en2) begin
      s2_q[0] <= mf3_pkg::max2(mf3_pkg::max2(lo_d[0], lo_d[1]), lo_d[2]);
      s2_q[1] <= mf3_pkg::med3(md_d[0], md_d[1], md_d[2]);
      s2_q[2] <= mf3_pkg::min2(mf3_pkg::min2(hi_d[0], hi_d[1]), hi_d[2]);
      f2_q    <= f1_q;
    end
    if (en3) begin
      s3_q <= mf3_pkg::med3(s2_q[0], s2_q[1], s2_q[2]);
      f3_q <= f2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_pixel_o = s3_q;
  assign out_flags_o = f3_q;

endmodule
